>>> src/bei_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bei_pkg;

    // number of motors by default
    localparam int MOTORS_DEF = 2;

    // field widths
    localparam int CMD_W       = 2;
    localparam int MIDX_IN_W   = 1;
    localparam int SAMPLE_W    = 10;
    localparam int ANGLE_W     = 16;
    localparam int MODE_W      = 2;
    localparam int POS_W       = 31;
    localparam int TARGET_W    = 24;
    localparam int THR_W       = 9;
    localparam int SCALE_W     = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;
    localparam int AMAG_W      = ANGLE_W + 1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ANGLE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MODE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    // motor modes
    localparam logic [MODE_W-1:0] MODE_STOP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FWD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BACK = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BAD  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SCALE      = 1'd1;

    // reset values
    localparam logic [THR_W-1:0]    THR_RESET    = 9'd16;
    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 8'd1;
    localparam logic [TARGET_W-1:0] TARGET_CONT  = 24'd1;

    // ADC word sign
    localparam logic [SAMPLE_W-1:0] SIGN_BIT = 10'h200;

    // per motor state
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [POS_W-1:0]    pos;
        logic [TARGET_W-1:0] target;
        logic                busy;
    } motor_state_t;

endpackage

`default_nettype wire

>>> src/bei_if.sv
`timescale 1ns / 1ps
`default_nettype none

// input item channel
interface bei_item_if;
    import bei_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [MIDX_IN_W-1:0] motor_index;
    logic [SAMPLE_W-1:0]  sample;
    logic signed [ANGLE_W-1:0] angle;
    logic [MODE_W-1:0]    mode_value;

    modport source (output valid, cmd, motor_index, sample, angle, mode_value,
                    input ready);
    modport sink (input valid, cmd, motor_index, sample, angle, mode_value,
                  output ready);
endinterface

// result item channel
interface bei_result_if;
    import bei_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic              busy_res;
    logic              reached;

    modport source (output valid, mode, position, busy_res, reached, input ready);
    modport sink (input valid, mode, position, busy_res, reached, output ready);
endinterface

// configuration write channel
interface bei_cfg_if;
    import bei_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/bei_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module bei_cfg
    import bei_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    bei_cfg_if.sink            cfg,
    output logic [THR_W-1:0]   offset_threshold,
    output logic [SCALE_W-1:0] angle_scale
);

    logic [THR_W-1:0]   thr_reg;
    logic [SCALE_W-1:0] scale_reg;

    // writes are always taken
    assign cfg.ready = 1'b1;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THR_RESET;
            scale_reg <= SCALE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_OFFSET_THRESHOLD: thr_reg   <= cfg.data[THR_W-1:0];
                REG_ANGLE_SCALE:      scale_reg <= cfg.data[SCALE_W-1:0];
                default:              ;
            endcase
        end
    end

    assign offset_threshold = thr_reg;
    assign angle_scale      = scale_reg;

endmodule

`default_nettype wire

>>> src/bei_step.sv
`timescale 1ns / 1ps
`default_nettype none

module bei_step
    import bei_pkg::*;
(
    input  wire logic [CMD_W-1:0]          cmd,
    input  wire logic [SAMPLE_W-1:0]       sample,
    input  wire logic signed [ANGLE_W-1:0] angle,
    input  wire logic [MODE_W-1:0]         mode_value,
    input  wire logic [THR_W-1:0]          offset_threshold,
    input  wire logic [SCALE_W-1:0]        angle_scale,
    input  wire motor_state_t              state_cur,
    output motor_state_t                   state_next,
    output logic                           reached
);

    logic [SAMPLE_W-1:0]        v;
    logic                       neg;
    logic [SAMPLE_W-1:0]        mag;
    logic [SAMPLE_W-1:0]        add;
    logic [POS_W:0]             sum;
    logic [POS_W-1:0]           pos_sat;
    logic [AMAG_W-1:0]          amag;
    logic [AMAG_W+SCALE_W-1:0]  product;

    // offset cut and mode dependent magnitude
    always_comb
    begin
        v = sample;
        if (v != '0 && v < {1'b0, offset_threshold})
            v = '0;
        neg = (v & SIGN_BIT) != '0;
        mag = ~v + SAMPLE_W'(1);
        unique case (state_cur.mode)
            MODE_FWD:  add = neg ? mag : '0;
            MODE_BACK: add = neg ? '0 : v;
            default:   add = neg ? mag : v;
        endcase
    end

    // saturating position add
    assign sum     = {1'b0, state_cur.pos} + {{(POS_W+1-SAMPLE_W){1'b0}}, add};
    assign pos_sat = sum[POS_W] ? {POS_W{1'b1}} : sum[POS_W-1:0];

    // angle magnitude and scaled target
    assign amag    = angle[ANGLE_W-1] ? (AMAG_W'(17'h10000) - {1'b0, angle})
                                      : {1'b0, angle};
    assign product = {{SCALE_W{1'b0}}, amag} * {{AMAG_W{1'b0}}, angle_scale};

    // next state per command
    always_comb
    begin
        state_next = state_cur;
        reached    = 1'b0;
        unique case (cmd)
            CMD_SAMPLE:
            begin
                state_next.pos = pos_sat;
                if (state_cur.target > TARGET_CONT && state_cur.mode != MODE_STOP &&
                    pos_sat >= {{(POS_W-TARGET_W){1'b0}}, state_cur.target})
                begin
                    state_next.mode = MODE_STOP;
                    state_next.pos  = '0;
                    state_next.busy = 1'b0;
                    reached         = 1'b1;
                end
            end
            CMD_ANGLE:
            begin
                state_next.pos = '0;
                if (angle == '0)
                begin
                    state_next.mode   = MODE_STOP;
                    state_next.target = '0;
                end
                else
                begin
                    state_next.mode = angle[ANGLE_W-1] ? MODE_BACK : MODE_FWD;
                    if (amag > AMAG_W'(1))
                    begin
                        state_next.target = product[TARGET_W-1:0];
                        state_next.busy   = 1'b1;
                    end
                    else
                    begin
                        state_next.target = TARGET_CONT;
                    end
                end
            end
            CMD_MODE:
            begin
                state_next.mode   = (mode_value == MODE_BAD) ? MODE_STOP : mode_value;
                state_next.target = TARGET_CONT;
            end
            CMD_NONE:
            begin
                state_next = state_cur;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/backemf_position_integrator.sv
`timescale 1ns / 1ps
`default_nettype none

// Back-EMF position integrator for up to MOTORS small DC motors.
// Channels: item (sink) carries one command per transaction: a back-EMF
// sample, an angle command or a mode command for the motor selected by
// motor_index. result (source) returns exactly one transaction per item
// with that motor's mode, position, busy flag and a reached flag.
// cfg (sink) writes offset_threshold (index 0) and angle_scale (index 1);
// it is always ready and should be written only while the block is idle.
// Path: an accepted item sits in the input register while the update logic
// computes, and the motor state and the result register are written at the
// same edge, once the result register is free.
// Throughput: one item per cycle while results are taken; the per-motor
// state is updated in place, so consecutive items to one motor need no wait.
// When the result receiver stalls, the result register holds, the input
// register fills and item.ready drops; nothing is lost.
// Reset: all motors stop, positions clear, targets are set to continuous
// running, busy flags clear and both registers take their default values.
module backemf_position_integrator
    import bei_pkg::*;
#(
    parameter int MOTORS = MOTORS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    bei_item_if.sink      item,
    bei_result_if.source  result,
    bei_cfg_if.sink       cfg
);

    localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    logic [THR_W-1:0]   offset_threshold;
    logic [SCALE_W-1:0] angle_scale;

    // input register
    logic                      s1_valid_reg;
    logic [CMD_W-1:0]          cmd_reg;
    logic [MIDX_IN_W-1:0]      midx_reg;
    logic [SAMPLE_W-1:0]       sample_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic [MODE_W-1:0]         mode_value_reg;

    // result register
    logic              out_valid_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [POS_W-1:0]  position_reg;
    logic              busy_reg;
    logic              reached_reg;

    motor_state_t      motor_state_reg [MOTORS];
    motor_state_t      state_cur;
    motor_state_t      state_next;
    logic              step_reached;
    logic [MIDX_W-1:0] idx;
    logic              in_range;
    logic              out_free;
    logic              s1_advance;

    bei_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .offset_threshold (offset_threshold),
        .angle_scale      (angle_scale)
    );

    // handshake
    assign out_free   = !out_valid_reg || result.ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign item.ready = !s1_valid_reg || out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (item.ready)
            s1_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            cmd_reg        <= item.cmd;
            midx_reg       <= item.motor_index;
            sample_reg     <= item.sample;
            angle_reg      <= item.angle;
            mode_value_reg <= item.mode_value;
        end
    end

    // motor select
    assign in_range  = int'(midx_reg) < MOTORS;
    assign idx       = in_range ? MIDX_W'(midx_reg) : '0;
    assign state_cur = motor_state_reg[idx];

    bei_step u_step (
        .cmd              (cmd_reg),
        .sample           (sample_reg),
        .angle            (angle_reg),
        .mode_value       (mode_value_reg),
        .offset_threshold (offset_threshold),
        .angle_scale      (angle_scale),
        .state_cur        (state_cur),
        .state_next       (state_next),
        .reached          (step_reached)
    );

    // motor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MOTORS; m++)
            begin
                motor_state_reg[m].mode   <= MODE_STOP;
                motor_state_reg[m].pos    <= '0;
                motor_state_reg[m].target <= TARGET_CONT;
                motor_state_reg[m].busy   <= 1'b0;
            end
        end
        else if (s1_advance && in_range)
        begin
            motor_state_reg[idx] <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            if (in_range)
            begin
                mode_reg     <= state_next.mode;
                position_reg <= state_next.pos;
                busy_reg     <= state_next.busy;
                reached_reg  <= step_reached;
            end
            else
            begin
                mode_reg     <= '0;
                position_reg <= '0;
                busy_reg     <= 1'b0;
                reached_reg  <= 1'b0;
            end
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.mode     = mode_reg;
    assign result.position = position_reg;
    assign result.busy_res = busy_reg;
    assign result.reached  = reached_reg;

endmodule

`default_nettype wire
